/* sv/assert_macros.svh */
// Assertion macros for the port-level checker of the allocator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* sv/ffsa_pkg.sv */
// Shared types, constants and helper functions of the first-fit slot allocator.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package ffsa_pkg;

	localparam int MAX_ROWS  = 4;
	localparam int MAX_UNITS = 16;

	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int UNIT_W    = $clog2(MAX_UNITS);
	localparam int ROWS_W    = 3;
	localparam int UNITS_W   = 5;
	localparam int FREE_W    = 7;
	localparam int SIZE_W    = 2;
	localparam int MASK_W    = MAX_UNITS + 1;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [ROWS_W-1:0]  ROWS_RESET  = ROWS_W'(4);
	localparam logic [UNITS_W-1:0] UNITS_RESET = UNITS_W'(16);
	localparam logic [FREE_W-1:0]  FREE_RESET  = FREE_W'(4 * 16);
	localparam logic [FREE_W-1:0]  FREE_MAX    = FREE_W'(MAX_ROWS * MAX_UNITS);

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_UNITS_PER_ROW = CFG_IDX_W'(1);

	localparam logic [SIZE_W-1:0] SIZE_ONE  = SIZE_W'(1);
	localparam logic [SIZE_W-1:0] SIZE_PAIR = SIZE_W'(2);

	typedef enum logic {
		OP_ALLOCATE = 1'b0,
		OP_RELEASE  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                operation;
		logic [SIZE_W-1:0]  request_size;
		logic [ROW_W-1:0]   release_row;
		logic [UNIT_W-1:0]  release_unit;
	} in_t;

	typedef struct packed {
		logic               granted;
		logic [ROW_W-1:0]   granted_row;
		logic [UNIT_W-1:0]  granted_unit;
		logic [FREE_W-1:0]  free_units;
	} out_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_needed;
		logic hit;
		logic scan_last;
		logic out_free;
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	function automatic logic [ROWS_W-1:0] eff_rows(input logic [ROWS_W-1:0] r);
		eff_rows = (r > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : r;
	endfunction

	function automatic logic [UNITS_W-1:0] eff_units(input logic [UNITS_W-1:0] u);
		eff_units = (u > UNITS_W'(MAX_UNITS)) ? UNITS_W'(MAX_UNITS) : u;
	endfunction

	function automatic logic [FREE_W-1:0] capacity(input logic [ROWS_W-1:0] r,
			input logic [UNITS_W-1:0] u);
		logic [ROWS_W+UNITS_W-1:0] p;
		p = eff_rows(r) * eff_units(u);
		capacity = p[FREE_W-1:0];
	endfunction

	function automatic logic size_ok(input logic [SIZE_W-1:0] s);
		size_ok = (s == SIZE_ONE) || (s == SIZE_PAIR);
	endfunction

endpackage

`default_nettype wire

/* sv/first_fit_slot_allocator.sv */
// First-fit slot allocator over an occupancy bitmap of up to 4 rows by 16
// units. A release, or an allocate that cannot scan (bad size, zero capacity),
// goes from acceptance straight to the finish state. An allocate first passes
// through the scan state, which inspects one unit per cycle until the first fit
// (or every unit of the clamped rows and units when none fits), and then the
// finish state. The finish state writes the result into the output register
// once that register is free; a result held there by a stalled output delays
// the write of the next result. One request is in flight at a time; a
// finished result waits in the output register while the next request is
// taken. A configuration write clears the map and sets the free count to the
// new capacity in the same cycle.
// Depends on ffsa_pkg, ffsa_ctrl and ffsa_dpath.
`default_nettype none

module first_fit_slot_allocator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire ffsa_pkg::in_t                   in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output ffsa_pkg::out_t                       out_data,
	input  wire logic                            cfg_we,
	input  wire logic [ffsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ffsa_pkg::CFG_DATA_W-1:0] cfg_data
);

	ffsa_pkg::cmd_t  cmd;
	ffsa_pkg::stat_t stat;

	ffsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffsa_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* sv/ffsa_ctrl.sv */
// Controller of the first-fit slot allocator: sequences load, scan and commit.
// Depends on ffsa_pkg for the command, status and state types.
`default_nettype none

module ffsa_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire ffsa_pkg::stat_t stat,
	output ffsa_pkg::cmd_t      cmd
);

	ffsa_pkg::state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ffsa_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.scan_needed ? ffsa_pkg::ST_SCAN : ffsa_pkg::ST_FINISH;
				end
			end
			ffsa_pkg::ST_SCAN: begin
				cmd.step = 1'b1;
				if (stat.hit || stat.scan_last) begin
					state_d = ffsa_pkg::ST_FINISH;
				end
			end
			ffsa_pkg::ST_FINISH: begin
				// hold the result until the output register can take it
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ffsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ffsa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ffsa_pkg::ST_IDLE);

endmodule

`default_nettype wire

/* sv/ffsa_dpath.sv */
// Datapath of the first-fit slot allocator: configuration, occupancy rows,
// free count, scan position and output register. Depends on ffsa_pkg.
`default_nettype none

module ffsa_dpath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ffsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ffsa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire ffsa_pkg::in_t                     in_data,
	input  wire ffsa_pkg::cmd_t                    cmd,
	output ffsa_pkg::stat_t                        stat,
	input  wire logic                              out_stall,
	output logic                                   out_valid,
	output ffsa_pkg::out_t                         out_data
);

	logic [ffsa_pkg::ROWS_W-1:0]    rows_q, rows_d, nr;
	logic [ffsa_pkg::UNITS_W-1:0]   units_q, units_d, nu;
	logic [ffsa_pkg::FREE_W-1:0]    cap;
	logic [ffsa_pkg::MAX_UNITS-1:0] occ_q [ffsa_pkg::MAX_ROWS];
	logic [ffsa_pkg::FREE_W-1:0]    free_q;

	ffsa_pkg::in_t                  req_q;
	logic [ffsa_pkg::ROW_W-1:0]     row_q;
	logic [ffsa_pkg::UNIT_W-1:0]    unit_q;
	logic                           grant_q;

	logic                           out_valid_q;
	ffsa_pkg::out_t                 out_q;

	logic [ffsa_pkg::MAX_UNITS-1:0] row_bits;
	logic [ffsa_pkg::UNITS_W-1:0]   unit_nx;
	logic [ffsa_pkg::ROWS_W-1:0]    row_nx;
	logic                           pair_in_row, hit, last;
	logic                           is_alloc, is_pair, rel_ok, granted_c;
	logic [ffsa_pkg::UNITS_W-1:0]   rel_unit_nx;
	logic [ffsa_pkg::ROW_W-1:0]     tgt_row;
	logic [ffsa_pkg::UNIT_W-1:0]    tgt_unit;
	logic [ffsa_pkg::MASK_W-1:0]    mask_w;
	logic [ffsa_pkg::MAX_UNITS-1:0] mask;
	logic [ffsa_pkg::FREE_W-1:0]    size_ext, free_dec, free_inc, free_next;

	// register file write
	always_comb begin
		rows_d  = rows_q;
		units_d = units_q;
		if (cfg_we) begin
			unique case (cfg_index)
				ffsa_pkg::REG_ROWS_IN_USE:   rows_d  = cfg_data[ffsa_pkg::ROWS_W-1:0];
				ffsa_pkg::REG_UNITS_PER_ROW: units_d = cfg_data[ffsa_pkg::UNITS_W-1:0];
			endcase
		end
	end

	assign nr  = ffsa_pkg::eff_rows(rows_q);
	assign nu  = ffsa_pkg::eff_units(units_q);
	assign cap = ffsa_pkg::capacity(rows_q, units_q);

	// one unit per scan step; the pair looks one unit ahead in the same row
	assign row_bits    = occ_q[row_q];
	assign unit_nx     = {1'b0, unit_q} + ffsa_pkg::UNITS_W'(1);
	assign row_nx      = {1'b0, row_q} + ffsa_pkg::ROWS_W'(1);
	assign pair_in_row = unit_nx < nu;
	assign is_pair     = (req_q.request_size == ffsa_pkg::SIZE_PAIR);
	assign hit         = !row_bits[unit_q] &&
		(!is_pair || (pair_in_row && !row_bits[unit_nx[ffsa_pkg::UNIT_W-1:0]]));
	assign last        = !pair_in_row && (row_nx >= nr);

	assign stat.scan_needed = (in_data.operation == ffsa_pkg::OP_ALLOCATE) &&
		ffsa_pkg::size_ok(in_data.request_size) && (cap != '0);
	assign stat.hit         = hit;
	assign stat.scan_last   = last;
	assign stat.out_free    = !out_valid_q || !out_stall;

	// release is honored only inside the configured geometry
	assign is_alloc    = (req_q.operation == ffsa_pkg::OP_ALLOCATE);
	assign rel_unit_nx = {1'b0, req_q.release_unit} + ffsa_pkg::UNITS_W'(1);
	assign rel_ok      = !is_alloc && ffsa_pkg::size_ok(req_q.request_size) &&
		({1'b0, req_q.release_row} < nr) && ({1'b0, req_q.release_unit} < nu) &&
		(!is_pair || (rel_unit_nx < nu));
	assign granted_c   = is_alloc ? grant_q : rel_ok;

	assign tgt_row  = is_alloc ? row_q : req_q.release_row;
	assign tgt_unit = is_alloc ? unit_q : req_q.release_unit;
	assign mask_w   = (is_pair ? ffsa_pkg::MASK_W'(3) : ffsa_pkg::MASK_W'(1)) << tgt_unit;
	assign mask     = mask_w[ffsa_pkg::MAX_UNITS-1:0];

	assign size_ext  = ffsa_pkg::FREE_W'(req_q.request_size);
	assign free_dec  = (free_q >= size_ext) ? (free_q - size_ext) : '0;
	assign free_inc  = ((free_q + size_ext) > cap) ? cap : (free_q + size_ext);
	assign free_next = granted_c ? (is_alloc ? free_dec : free_inc) : free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= ffsa_pkg::ROWS_RESET;
			units_q <= ffsa_pkg::UNITS_RESET;
			free_q  <= ffsa_pkg::FREE_RESET;
			for (int r = 0; r < ffsa_pkg::MAX_ROWS; r++) begin
				occ_q[r] <= '0;
			end
		end else if (cfg_we) begin
			// any register write restarts the allocator with an empty map
			rows_q  <= rows_d;
			units_q <= units_d;
			free_q  <= ffsa_pkg::capacity(rows_d, units_d);
			for (int r = 0; r < ffsa_pkg::MAX_ROWS; r++) begin
				occ_q[r] <= '0;
			end
		end else if (cmd.commit && granted_c) begin
			free_q <= free_next;
			for (int r = 0; r < ffsa_pkg::MAX_ROWS; r++) begin
				if (ffsa_pkg::ROW_W'(r) == tgt_row) begin
					occ_q[r] <= is_alloc ? (occ_q[r] | mask) : (occ_q[r] & ~mask);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			unit_q  <= '0;
			grant_q <= 1'b0;
		end else if (cmd.load) begin
			row_q   <= '0;
			unit_q  <= '0;
			grant_q <= 1'b0;
		end else if (cmd.step) begin
			if (hit) begin
				grant_q <= 1'b1;
			end else if (!last) begin
				if (pair_in_row) begin
					unit_q <= unit_nx[ffsa_pkg::UNIT_W-1:0];
				end else begin
					unit_q <= '0;
					row_q  <= row_nx[ffsa_pkg::ROW_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.granted      <= granted_c;
			out_q.granted_row  <= granted_c ? tgt_row : '0;
			out_q.granted_unit <= granted_c ? tgt_unit : '0;
			out_q.free_units   <= free_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

/* sv/ffsa_checker.sv */
// Port-level checker of the first-fit slot allocator, bound to the top level.
// Depends on ffsa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ffsa_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_stall,
	input wire logic           out_valid,
	input wire logic           out_stall,
	input wire ffsa_pkg::out_t out_data
);

	// one request at a time: the port closes right after a transaction
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && !in_stall, in_stall)

	// a refused request reports row and unit as zero
	`ASSERT_IMPLIES(a_refused_zero, clk, arst_n, out_valid && !out_data.granted, out_data.granted_row == '0 && out_data.granted_unit == '0)

	// the free count never exceeds the largest map
	`ASSERT_IMPLIES(a_free_bound, clk, arst_n, out_valid, out_data.free_units <= ffsa_pkg::FREE_MAX)

	`ASSERT_NEXT(a_out_hold_valid, clk, arst_n, out_valid && out_stall, out_valid)

	`ASSERT_NEXT(a_out_hold_data, clk, arst_n, out_valid && out_stall, $stable(out_data))

endmodule

bind first_fit_slot_allocator ffsa_checker u_ffsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire

/* bench/slot_grant_checker.sv */
// Checker for the first-fit slot allocator: watches the request, result and register ports,
// predicts each grant from its own copy of the occupancy map and compares in order.
// Depends on ffsa_pkg for the payload types, sizes and register indexes.
`timescale 1ns / 100ps

module slot_grant_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  ffsa_pkg::in_t                   in_data,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  ffsa_pkg::out_t                  out_data,
	input  logic                            cfg_we,
	input  logic [ffsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ffsa_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                     pending,
	output int unsigned                     errors
);
	import ffsa_pkg::*;

	logic [ROWS_W-1:0]  rows_reg;
	logic [UNITS_W-1:0] units_reg;
	bit                 occupied [MAX_ROWS][MAX_UNITS];
	int unsigned        free_left;
	out_t               expected_grants [$];
	out_t               want;

	function automatic int unsigned rows_active();
		return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
	endfunction

	function automatic int unsigned units_active();
		return (units_reg > MAX_UNITS) ? MAX_UNITS : int'(units_reg);
	endfunction

	// Any register write starts over with an empty map.
	function automatic void clear_map();
		foreach (occupied[r, u])
			occupied[r][u] = 1'b0;
		free_left = rows_active() * units_active();
	endfunction

	function automatic out_t serve_request(in_t req);
		out_t        res;
		int unsigned nr, nu, cap, sz, rr, ru;
		int          gr, gu;
		bit          hit;
		res = '0;
		nr  = rows_active();
		nu  = units_active();
		cap = nr * nu;
		sz  = req.request_size;
		hit = 1'b0;
		gr  = 0;
		gu  = 0;
		if (sz == 1 || sz == 2) begin
			if (req.operation == OP_ALLOCATE) begin
				for (int r = 0; r < nr && !hit; r++) begin
					for (int u = 0; u < nu && !hit; u++) begin
						// a pair must fit inside the row
						if (!occupied[r][u] &&
								(sz == 1 || (u + 1 < nu && !occupied[r][u + 1]))) begin
							hit = 1'b1;
							gr  = r;
							gu  = u;
						end
					end
				end
				if (hit) begin
					occupied[gr][gu] = 1'b1;
					if (sz == 2)
						occupied[gr][gu + 1] = 1'b1;
					free_left = (free_left >= sz) ? free_left - sz : 0;
					res.granted      = 1'b1;
					res.granted_row  = ROW_W'(gr);
					res.granted_unit = UNIT_W'(gu);
				end
			end else begin
				rr = req.release_row;
				ru = req.release_unit;
				if (rr < nr && ru < nu && (sz == 1 || ru + 1 < nu)) begin
					occupied[rr][ru] = 1'b0;
					if (sz == 2)
						occupied[rr][ru + 1] = 1'b0;
					// releasing free units still raises the count, up to capacity
					free_left = free_left + sz;
					if (free_left > cap)
						free_left = cap;
					res.granted      = 1'b1;
					res.granted_row  = req.release_row;
					res.granted_unit = req.release_unit;
				end
			end
		end
		res.free_units = FREE_W'(free_left);
		return res;
	endfunction

	task automatic log_failure(string what, out_t exp_res, out_t got);
		errors++;
		if (errors <= 10)
			$display("%0t: %s: expected granted=%0d row=%0d unit=%0d free=%0d, got granted=%0d row=%0d unit=%0d free=%0d",
				$time, what, exp_res.granted, exp_res.granted_row, exp_res.granted_unit,
				exp_res.free_units, got.granted, got.granted_row, got.granted_unit,
				got.free_units);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg  = ROWS_RESET;
			units_reg = UNITS_RESET;
			clear_map();
			expected_grants.delete();
			pending = 0;
			errors  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS_IN_USE:   rows_reg  = cfg_data[ROWS_W-1:0];
					REG_UNITS_PER_ROW: units_reg = cfg_data[UNITS_W-1:0];
					default: ;
				endcase
				clear_map();
			end
			if (in_valid && !in_stall)
				expected_grants.push_back(serve_request(in_data));
			if (out_valid && !out_stall) begin
				if (expected_grants.size() == 0) begin
					log_failure("result with no request outstanding", '0, out_data);
				end else begin
					want = expected_grants.pop_front();
					if (out_data.granted !== want.granted ||
							out_data.granted_row !== want.granted_row ||
							out_data.granted_unit !== want.granted_unit ||
							out_data.free_units !== want.free_units)
						log_failure("result mismatch", want, out_data);
				end
			end
			pending = expected_grants.size();
		end
	end

endmodule

/* bench/first_fit_slot_allocator_test.sv */
// Top of the allocator testbench: clock, reset, request and register stimulus, result stall.
// Depends on ffsa_pkg, first_fit_slot_allocator and slot_grant_checker.
`timescale 1ns / 100ps

module first_fit_slot_allocator_test;
	import ffsa_pkg::*;

	localparam logic [SIZE_W-1:0] SIZE_NONE = SIZE_W'(0);
	localparam logic [SIZE_W-1:0] SIZE_OVER = SIZE_W'(3);
	localparam int unsigned RANDOM_ITEMS = 1300;

	typedef enum {STALL_FLOW, STALL_HOLD, STALL_FLICKER} stall_mode_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_t                   in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int unsigned           pending;
	int unsigned           errors;

	int unsigned           burst_left;
	int unsigned           stall_run;
	stall_mode_t           stall_mode;
	logic [ROWS_W-1:0]     rows_now = ROWS_RESET;
	logic [UNITS_W-1:0]    units_now = UNITS_RESET;

	first_fit_slot_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	slot_grant_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.errors    (errors)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: runs of open flow, solid stall, or coin-flip stall.
	always @(negedge clk) begin
		if (stall_run == 0) begin
			case ($urandom_range(0, 3))
				0, 1: stall_mode = STALL_FLOW;
				2: stall_mode = STALL_HOLD;
				default: stall_mode = STALL_FLICKER;
			endcase
			stall_run = $urandom_range(1, 20);
		end
		stall_run--;
		case (stall_mode)
			STALL_FLOW: out_stall <= 1'b0;
			STALL_HOLD: out_stall <= 1'b1;
			default:    out_stall <= 1'($urandom_range(0, 1));
		endcase
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_request(input op_t op, input logic [SIZE_W-1:0] size,
			input logic [ROW_W-1:0] row, input logic [UNIT_W-1:0] unit);
		in_t req;
		int unsigned gap;
		req.operation    = op;
		req.request_size = size;
		req.release_row  = row;
		req.release_unit = unit;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 8);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= req;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
	endtask

	// Drain everything in flight, then write one register.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk) in_valid <= 1'b0;
		burst_left = 0;
		wait (pending == 0);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk) cfg_we <= 1'b0;
		if (idx == REG_ROWS_IN_USE)
			rows_now = data[ROWS_W-1:0];
		else
			units_now = data[UNITS_W-1:0];
	endtask

	task automatic send_random(input int unsigned alloc_pct);
		int unsigned nr, nu;
		logic [SIZE_W-1:0] size;
		nr = (rows_now > MAX_ROWS) ? MAX_ROWS : rows_now;
		nu = (units_now > MAX_UNITS) ? MAX_UNITS : units_now;
		size = ($urandom_range(0, 1) == 0) ? SIZE_ONE : SIZE_PAIR;
		if ($urandom_range(0, 99) < 8 || nr == 0 || nu == 0) begin
			// noise: any field value at all
			send_request(op_t'($urandom_range(0, 1)), SIZE_W'($urandom_range(0, 3)),
				ROW_W'($urandom_range(0, 3)), UNIT_W'($urandom_range(0, 15)));
		end else if ($urandom_range(0, 99) < alloc_pct) begin
			send_request(OP_ALLOCATE, size, ROW_W'($urandom_range(0, 3)),
				UNIT_W'($urandom_range(0, 15)));
		end else begin
			if (nu < 2)
				size = SIZE_ONE;
			send_request(OP_RELEASE, size, ROW_W'($urandom_range(0, nr - 1)),
				UNIT_W'($urandom_range(0, (size == SIZE_PAIR) ? nu - 2 : nu - 1)));
		end
	endtask

	initial begin
		int unsigned random_sent;
		int unsigned phase_len;
		int unsigned alloc_pct;
		logic [ROWS_W-1:0]  rows_pick;
		logic [UNITS_W-1:0] units_pick;
		random_sent = 0;
		burst_left  = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// full 4 x 16 map after reset
		send_request(OP_ALLOCATE, SIZE_ONE, 0, 0);
		send_request(OP_ALLOCATE, SIZE_PAIR, 0, 0);
		send_request(OP_RELEASE, SIZE_ONE, 0, 0);
		send_request(OP_ALLOCATE, SIZE_PAIR, 0, 0);
		send_request(OP_RELEASE, SIZE_ONE, 3, 15);
		send_request(OP_RELEASE, SIZE_PAIR, 3, 15);
		send_request(OP_ALLOCATE, SIZE_NONE, 0, 0);
		send_request(OP_ALLOCATE, SIZE_OVER, 3, 15);
		send_request(OP_RELEASE, SIZE_NONE, 0, 1);
		send_request(OP_RELEASE, SIZE_OVER, 1, 1);

		// one row of three units: fill it, then look for no room
		write_register(REG_ROWS_IN_USE, 1);
		write_register(REG_UNITS_PER_ROW, 3);
		send_request(OP_ALLOCATE, SIZE_PAIR, 0, 0);
		send_request(OP_ALLOCATE, SIZE_PAIR, 0, 0);
		send_request(OP_ALLOCATE, SIZE_ONE, 0, 0);
		send_request(OP_ALLOCATE, SIZE_ONE, 0, 0);
		send_request(OP_RELEASE, SIZE_PAIR, 0, 1);
		send_request(OP_ALLOCATE, SIZE_PAIR, 0, 0);
		send_request(OP_RELEASE, SIZE_ONE, 1, 0);
		send_request(OP_RELEASE, SIZE_ONE, 0, 3);

		// zero capacity
		write_register(REG_ROWS_IN_USE, 0);
		send_request(OP_ALLOCATE, SIZE_ONE, 0, 0);
		send_request(OP_RELEASE, SIZE_ONE, 0, 0);

		// oversized register values clamp; upper data bits are dropped for rows
		write_register(REG_ROWS_IN_USE, 28);
		write_register(REG_UNITS_PER_ROW, 31);
		send_request(OP_RELEASE, SIZE_ONE, 3, 15);
		send_request(OP_ALLOCATE, SIZE_ONE, 0, 0);

		// single-unit rows never hold a pair
		write_register(REG_UNITS_PER_ROW, 1);
		send_request(OP_ALLOCATE, SIZE_PAIR, 0, 0);
		send_request(OP_ALLOCATE, SIZE_ONE, 0, 0);
		send_request(OP_RELEASE, SIZE_PAIR, 0, 0);
		write_register(REG_UNITS_PER_ROW, 0);
		send_request(OP_ALLOCATE, SIZE_ONE, 0, 0);

		while (random_sent < RANDOM_ITEMS) begin
			rows_pick = ($urandom_range(0, 9) == 0) ? 0 : ROWS_W'($urandom_range(1, 7));
			if ($urandom_range(0, 15) == 0)
				units_pick = 0;
			else if ($urandom_range(0, 3) == 0)
				units_pick = UNITS_W'($urandom_range(17, 31));
			else
				units_pick = UNITS_W'($urandom_range(1, 16));
			write_register(REG_ROWS_IN_USE, {2'($urandom_range(0, 3)), rows_pick});
			write_register(REG_UNITS_PER_ROW, units_pick);
			phase_len = $urandom_range(30, 120);
			alloc_pct = $urandom_range(40, 80);
			repeat (phase_len) begin
				send_random(alloc_pct);
				random_sent++;
			end
		end

		@(negedge clk) in_valid <= 1'b0;
		wait (pending == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
